// ===== rtl/core/sst_pkg.sv =====
`default_nettype none
package sst_pkg;

  // Values and masks carried by one item.
  localparam int unsigned PAIRS   = 3;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned PAIR_W  = 7;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned LINE_W  = 3;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 16;

  localparam logic [PAIR_W-1:0]   MAX_VALUE    = 7'd99;
  localparam logic [SEG_W-1:0]    POINT_BIT    = 8'b0000_0001;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [MASK_W-1:0]   POINT_RESET  = 6'b001010;

  typedef enum logic [0:0] {
    CFG_BLINK_PERIOD = 1'b0,
    CFG_POINT_MASK   = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_0;
    logic [PAIR_W-1:0] pair_1;
    logic [PAIR_W-1:0] pair_2;
    logic [MASK_W-1:0] blank_bits;
  } sst_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] digit_line;
    logic [SEG_W-1:0]  segments;
    logic              last;
  } sst_out_t;

  // Segment pattern for a decimal digit; bit 0 is left free for the point.
  function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0:    seg = 8'b1111_1010;
      4'd1:    seg = 8'b0010_0010;
      4'd2:    seg = 8'b0111_1100;
      4'd3:    seg = 8'b0111_0110;
      4'd4:    seg = 8'b1010_0110;
      4'd5:    seg = 8'b1101_0110;
      4'd6:    seg = 8'b1101_1110;
      4'd7:    seg = 8'b0110_0010;
      4'd8:    seg = 8'b1111_1110;
      4'd9:    seg = 8'b1111_0110;
      default: seg = '0;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/seven_segment_time_scanner.sv =====
// Seven-segment scanner: each accepted item (three time values and a blink
// mask) produces DIGITS results, one per clock cycle, on the out channel,
// tens then ones of each value, the enable line counting down from DIGITS-1
// to 0 and last marking the final digit. An item occupies the block until its
// last digit is emitted, paced by the single digit-scan register that steps
// through the stored digits into the output register; the next item is taken
// in the same cycle as the previous item's last digit moves into the output
// register, so a steady stream of items runs with no gap. A stall on the
// output holds the scan where it is.
// The blink countdown steps once per digit emitted, and a new blink period
// takes effect at the next reload.
`default_nettype none
module seven_segment_time_scanner
  import sst_pkg::*;
#(
  parameter int unsigned DIGITS = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire sst_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sst_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int unsigned IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIGITS - 1);
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(DIGITS - 1);

  logic [PERIOD_W-1:0] blink_period_r;
  logic [MASK_W-1:0]   point_mask_r;
  logic                blink_phase_r;
  logic [PERIOD_W-1:0] blink_cnt_r;

  logic                busy_r;
  logic [IDX_W-1:0]    idx_r;
  logic [DIGIT_W-1:0]  digits_r [DIGITS];
  logic [DIGITS-1:0]   blink_r;

  logic                out_valid_r;
  sst_out_t            out_data_r;

  logic [DIGIT_W-1:0]  split_digit [2*PAIRS];
  logic [DIGIT_W-1:0]  digits_nxt [DIGITS];
  logic [DIGITS-1:0]   blink_nxt;
  logic [DIGITS-1:0]   point_ext;
  logic                advance;
  logic                last_digit;
  logic                accept;
  logic [SEG_W-1:0]    seg_nxt;

  sst_split u_split0 (.pair(in_data.pair_0), .tens(split_digit[0]), .ones(split_digit[1]));
  sst_split u_split1 (.pair(in_data.pair_1), .tens(split_digit[2]), .ones(split_digit[3]));
  sst_split u_split2 (.pair(in_data.pair_2), .tens(split_digit[4]), .ones(split_digit[5]));

  // Digits beyond the carried pairs show zero with point and blink clear.
  for (genvar g = 0; g < DIGITS; g++) begin : g_digit
    if (g < 2 * PAIRS) begin : g_real
      assign digits_nxt[g] = split_digit[g];
      assign blink_nxt[g]  = in_data.blank_bits[g];
      assign point_ext[g]  = point_mask_r[g];
    end else begin : g_pad
      assign digits_nxt[g] = '0;
      assign blink_nxt[g]  = 1'b0;
      assign point_ext[g]  = 1'b0;
    end
  end

  assign advance    = busy_r && (!out_valid_r || !out_stall);
  assign last_digit = (idx_r == LAST_IDX);
  assign in_stall   = busy_r && !(advance && last_digit);
  assign accept     = in_valid && !in_stall;

  always_comb begin
    seg_nxt = seg_of(digits_r[idx_r]);
    if (point_ext[idx_r]) begin
      seg_nxt = seg_nxt | POINT_BIT;
    end
    if (blink_r[idx_r] && !blink_phase_r) begin
      seg_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r <= PERIOD_RESET;
      point_mask_r   <= POINT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_PERIOD: blink_period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_POINT_MASK:   point_mask_r   <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_phase_r <= 1'b0;
      blink_cnt_r   <= PERIOD_RESET;
    end else if (advance) begin
      if (blink_cnt_r == '0) begin
        blink_cnt_r   <= blink_period_r;
        blink_phase_r <= !blink_phase_r;
      end else begin
        blink_cnt_r <= blink_cnt_r - PERIOD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (advance) begin
      if (last_digit) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      digits_r <= digits_nxt;
      blink_r  <= blink_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.digit_line <= LAST_LINE - LINE_W'(idx_r);
      out_data_r.segments   <= seg_nxt;
      out_data_r.last       <= last_digit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/sst_split.sv =====
`default_nettype none
module sst_split
  import sst_pkg::*;
(
  input  wire logic [PAIR_W-1:0]  pair,
  output logic      [DIGIT_W-1:0] tens,
  output logic      [DIGIT_W-1:0] ones
);

  logic [PAIR_W-1:0]  value;
  logic [14:0]        scaled;
  logic [PAIR_W-1:0]  tens_x10;

  // Multiplying by 205/2048 gives the exact tens digit for every value up to 99.
  always_comb begin
    value    = (pair > MAX_VALUE) ? MAX_VALUE : pair;
    scaled   = 15'(value) * 15'd205;
    tens     = DIGIT_W'(scaled >> 11);
    tens_x10 = PAIR_W'({tens, 3'b000}) + PAIR_W'({tens, 1'b0});
    ones     = DIGIT_W'(value - tens_x10);
  end

endmodule
`default_nettype wire

// ===== rtl/core/sst_checker.sv =====
`default_nettype none
module sst_checker
  import sst_pkg::*;
#(
  parameter int unsigned DIGITS = 6
) (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire sst_out_t out_data
);

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(DIGITS - 1);

  // A result held back by the consumer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An item is scanned one digit at a time, so the input closes after an accept.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted straight after the first");

  // The last flag goes with enable line zero and nothing else.
  a_last_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.digit_line == '0)))
    else $error("last flag does not match enable line");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.digit_line <= LAST_LINE)
    else $error("enable line out of range");

endmodule

bind seven_segment_time_scanner sst_checker #(.DIGITS(DIGITS)) u_sst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
